/* rtl/segment_page_translate_alloc_core_assert.svh */
// assertion macros for the port-level checker
`ifndef SEGMENT_PAGE_TRANSLATE_ALLOC_CORE_ASSERT_SVH
`define SEGMENT_PAGE_TRANSLATE_ALLOC_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define SPT_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is low
`define SPT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/spt_pkg.sv */
// package: sizes, codes and derived constants of the translate block
`timescale 1ns / 1ps
package spt_pkg;

  localparam int FRAME_COUNT = 1024;
  localparam int FRAME_WORDS = 512;   // power of two
  localparam int MEM_WORDS   = 524288; // power of two

  localparam int ENTRY_W = 20;
  localparam int ADDR_W  = 19;
  localparam int ACT_W   = 2;
  localparam int SEG_W   = 9;
  localparam int PAGE_W  = 10;
  localparam int OFF_W   = 9;
  localparam int STAT_W  = 2;

  localparam int MEM_AW = $clog2(MEM_WORDS);
  localparam int FW_SH  = $clog2(FRAME_WORDS);

  // frames that fit the frame count, the memory and a positive entry
  localparam int MEM_FRAMES = MEM_WORDS / FRAME_WORDS;
  localparam int EXT_FRAMES = ((2 ** ADDR_W) + FRAME_WORDS - 1) / FRAME_WORDS;
  localparam int USABLE_A   = (MEM_FRAMES < FRAME_COUNT) ? MEM_FRAMES : FRAME_COUNT;
  localparam int USABLE     = (EXT_FRAMES < USABLE_A) ? EXT_FRAMES : USABLE_A;

  // frame bitmap is kept as rows of ROW_W bits
  localparam int ROW_W    = 32;
  localparam int ROW_BW   = $clog2(ROW_W);
  localparam int ROWS     = (USABLE + ROW_W - 1) / ROW_W;
  localparam int ROW_AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int FRAME_BW = ROW_AW + ROW_BW;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FAULT = 2'd1,
    ST_ERR   = 2'd2,
    ST_OOF   = 2'd3
  } status_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_READ      = 2'd0,
    ACT_WRITE     = 2'd1,
    ACT_LOAD_SEG  = 2'd2,
    ACT_LOAD_PAGE = 2'd3
  } action_e;

endpackage

/* rtl/spt_if.sv */
// request and result channel interfaces
`timescale 1ns / 1ps
interface spt_in_if import spt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [ACT_W-1:0]          action;
  logic [SEG_W-1:0]          segment;
  logic [PAGE_W-1:0]         page;
  logic [OFF_W-1:0]          offset;
  logic signed [ENTRY_W-1:0] entry_value;

  modport source (output valid, action, segment, page, offset, entry_value, input ready);
  modport sink   (input valid, action, segment, page, offset, entry_value, output ready);
endinterface

interface spt_out_if import spt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [ADDR_W-1:0] phys_addr;

  modport source (output valid, status, phys_addr, input ready);
  modport sink   (input valid, status, phys_addr, output ready);
endinterface

/* rtl/spt_ram.sv */
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module spt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

/* rtl/segment_page_translate_alloc_core.sv */
// top level: segment/page translation with first-fit frame allocation
// a translate hit reads the segment entry, then the page entry, then hands on the result
// allocating write: bitmap scan of 32-frame rows over up to 2*ROWS rows, then a read and a
// write-back for each of up to 3 marked frames, up to 2 table writes and the result
// throughput: one item at a time, set by the single table memory read port and bitmap scan
// reset: async low; a clearing pass zeroes every table memory word, in ready low
`timescale 1ns / 1ps
module segment_page_translate_alloc_core import spt_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  spt_in_if.sink        in_i,
  spt_out_if.source     out_o
);

  // sequencer codes
  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RSEG = 4'd2;  // segment entry returns
  localparam logic [3:0] S_RPG  = 4'd3;  // page entry returns
  localparam logic [3:0] S_SRD  = 4'd4;  // bitmap row read for search
  localparam logic [3:0] S_SCHK = 4'd5;  // bitmap row examined
  localparam logic [3:0] S_MRD  = 4'd6;  // bitmap row read for marking
  localparam logic [3:0] S_MWR  = 4'd7;  // bitmap row written back
  localparam logic [3:0] S_TW   = 4'd8;  // table entry writes
  localparam logic [3:0] S_DONE = 4'd9;  // result handed to output register

  // first set bit, lowest index wins
  function automatic logic [ROW_BW-1:0] first_set(input logic [ROW_W-1:0] v);
    logic [ROW_BW-1:0] r;
    r = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (v[i]) r = ROW_BW'(i);
    end
    return r;
  endfunction

  // control state
  logic [3:0]        state_q, state_d;
  logic [MEM_AW-1:0] clr_q, clr_d;
  logic              out_valid_q, out_valid_d;
  logic [ROWS-1:0]   bm_vld_q, bm_vld_d;
  logic [ROW_AW-1:0] row_q, row_d;
  logic              scan_pair_q, scan_pair_d;
  logic              have_pt_q, have_pt_d;
  logic              prev_free_q, prev_free_d;
  logic [1:0]        mk_n_q, mk_n_d;
  logic [1:0]        mk_i_q, mk_i_d;
  logic              tw_two_q, tw_two_d;
  logic              tw_i_q, tw_i_d;

  // payload state
  logic [ACT_W-1:0]          act_q, act_d;
  logic [SEG_W-1:0]          seg_q, seg_d;
  logic [PAGE_W-1:0]         pg_q, pg_d;
  logic [OFF_W-1:0]          off_q, off_d;
  logic signed [ENTRY_W-1:0] val_q, val_d;
  logic [MEM_AW-1:0]         pg_addr_q, pg_addr_d;
  logic [FRAME_BW-1:0]       pt_q, pt_d;
  logic [FRAME_BW-1:0]       mk_q [3];
  logic [FRAME_BW-1:0]       mk_d [3];
  logic [MEM_AW-1:0]         tw_addr_q [2];
  logic [MEM_AW-1:0]         tw_addr_d [2];
  logic [ENTRY_W-1:0]        tw_data_q [2];
  logic [ENTRY_W-1:0]        tw_data_d [2];
  logic [STAT_W-1:0]         res_st_q, res_st_d;
  logic [ADDR_W-1:0]         res_pa_q, res_pa_d;
  logic [STAT_W-1:0]         out_st_q, out_st_d;
  logic [ADDR_W-1:0]         out_pa_q, out_pa_d;
  logic [ROW_AW-1:0]         bm_rrow_q;

  // table memory
  logic               t_we;
  logic [MEM_AW-1:0]  t_waddr, t_raddr;
  logic [ENTRY_W-1:0] t_wdata, t_rdata;

  spt_ram #(.WIDTH(ENTRY_W), .DEPTH(MEM_WORDS)) u_table (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_waddr),
    .wdata_i (t_wdata),
    .raddr_i (t_raddr),
    .rdata_o (t_rdata)
  );

  // frame bitmap memory
  logic              bm_we;
  logic [ROW_AW-1:0] bm_waddr, bm_raddr;
  logic [ROW_W-1:0]  bm_wdata, bm_rdata;

  spt_ram #(.WIDTH(ROW_W), .DEPTH(ROWS)) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (bm_we),
    .waddr_i (bm_waddr),
    .wdata_i (bm_wdata),
    .raddr_i (bm_raddr),
    .rdata_o (bm_rdata)
  );

  // entry returned by the table memory
  logic signed [ENTRY_W-1:0] rd_ent;
  logic [ENTRY_W:0]          ent_pg_sum, ent_off_sum;
  assign rd_ent      = signed'(t_rdata);
  assign ent_pg_sum  = {1'b0, t_rdata} + (ENTRY_W + 1)'(pg_q);
  assign ent_off_sum = {1'b0, t_rdata} + (ENTRY_W + 1)'(off_q);

  // load entry checks: frame of the entry and room for n frames
  logic [ENTRY_W:0] val_frame;
  logic             val_pos, bad_seg_load, bad_pg_load;
  assign val_frame    = {1'b0, val_q} >> FW_SH;
  assign val_pos      = val_q > 0;
  assign bad_seg_load = (val_q < -20'sd1) ||
                        (val_pos && (val_frame + 21'd2 > (ENTRY_W + 1)'(USABLE)));
  assign bad_pg_load  = (val_q < -20'sd1) ||
                        (val_pos && (val_frame + 21'd1 > (ENTRY_W + 1)'(USABLE)));

  // bitmap row as seen: rows never written read as their reset value
  logic [ROW_W-1:0] bm_eff;
  assign bm_eff = bm_vld_q[bm_rrow_q] ? bm_rdata :
                  ((bm_rrow_q == '0) ? ROW_W'(1) : '0);

  // search view: frames past the usable range and a table just found count as used
  logic [FRAME_BW-1:0] row_base;
  logic [ROW_W-1:0]    srch_free;
  logic [ROW_W-1:0]    pair_v;
  assign row_base = {row_q, {ROW_BW{1'b0}}};

  always_comb begin
    logic [FRAME_BW-1:0] idx;
    logic                used;
    for (int j = 0; j < ROW_W; j++) begin
      idx  = row_base + FRAME_BW'(j);
      used = bm_eff[j] || ({1'b0, idx} >= (FRAME_BW + 1)'(USABLE)) ||
             (have_pt_q && ((idx == pt_q) || (idx == pt_q + 1'b1)));
      srch_free[j] = !used;
    end
  end

  // bit 0 is a pair crossing in from the previous row, bit k a pair starting at frame k-1
  always_comb begin
    pair_v[0] = prev_free_q && srch_free[0] && (row_q != '0);
    for (int j = 0; j < ROW_W - 1; j++) begin
      pair_v[j + 1] = srch_free[j] && srch_free[j + 1];
    end
  end

  logic [FRAME_BW-1:0] pair_start, single_frame;
  logic [ENTRY_W-1:0]  pta, pga;
  logic [ENTRY_W:0]    pta_pg_sum, pga_off_sum;
  assign pair_start   = row_base + FRAME_BW'(first_set(pair_v)) - 1'b1;
  assign single_frame = row_base + FRAME_BW'(first_set(srch_free));
  assign pta          = ENTRY_W'(pt_q) << FW_SH;
  assign pga          = ENTRY_W'(single_frame) << FW_SH;
  assign pta_pg_sum   = {1'b0, pta} + (ENTRY_W + 1)'(pg_q);
  assign pga_off_sum  = {1'b0, pga} + (ENTRY_W + 1)'(off_q);

  logic [FRAME_BW-1:0] mk_cur;
  assign mk_cur = mk_q[mk_i_q];

  assign in_i.ready      = (state_q == S_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.status    = out_st_q;
  assign out_o.phys_addr = out_pa_q;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q;
    bm_vld_d    = bm_vld_q;
    row_d       = row_q;
    scan_pair_d = scan_pair_q;
    have_pt_d   = have_pt_q;
    prev_free_d = prev_free_q;
    mk_n_d      = mk_n_q;
    mk_i_d      = mk_i_q;
    tw_two_d    = tw_two_q;
    tw_i_d      = tw_i_q;
    act_d       = act_q;
    seg_d       = seg_q;
    pg_d        = pg_q;
    off_d       = off_q;
    val_d       = val_q;
    pg_addr_d   = pg_addr_q;
    pt_d        = pt_q;
    mk_d        = mk_q;
    tw_addr_d   = tw_addr_q;
    tw_data_d   = tw_data_q;
    res_st_d    = res_st_q;
    res_pa_d    = res_pa_q;
    out_st_d    = out_st_q;
    out_pa_d    = out_pa_q;

    t_we     = 1'b0;
    t_waddr  = clr_q;
    t_wdata  = '0;
    t_raddr  = MEM_AW'(in_i.segment) & MEM_AW'(FRAME_WORDS - 1);
    bm_we    = 1'b0;
    bm_waddr = bm_rrow_q;
    bm_wdata = bm_eff | (ROW_W'(1) << mk_cur[ROW_BW-1:0]);
    bm_raddr = row_q;

    // result register drains independently of the sequencer
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLR: begin
        // zero one table word per cycle
        t_we    = 1'b1;
        t_waddr = clr_q;
        clr_d   = clr_q + 1'b1;
        if (clr_q == MEM_AW'(MEM_WORDS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_i.valid) begin
          act_d    = in_i.action;
          seg_d    = in_i.segment & SEG_W'(FRAME_WORDS - 1);
          pg_d     = in_i.page & PAGE_W'(2 * FRAME_WORDS - 1);
          off_d    = in_i.offset & OFF_W'(FRAME_WORDS - 1);
          val_d    = in_i.entry_value;
          res_st_d = ST_OK;
          res_pa_d = '0;
          mk_n_d   = 2'd0;
          mk_i_d   = 2'd0;
          tw_two_d = 1'b0;
          tw_i_d   = 1'b0;
          state_d  = S_RSEG;
        end
      end
      S_RSEG: begin
        pg_addr_d = ent_pg_sum[MEM_AW-1:0];
        case (act_q)
          ACT_LOAD_SEG: begin
            if (bad_seg_load) begin
              res_st_d = ST_ERR;
              state_d  = S_DONE;
            end else begin
              tw_addr_d[0] = MEM_AW'(seg_q);
              tw_data_d[0] = val_q;
              mk_d[0]      = FRAME_BW'(val_frame);
              mk_d[1]      = FRAME_BW'(val_frame) + 1'b1;
              mk_n_d       = val_pos ? 2'd2 : 2'd0;
              state_d      = val_pos ? S_MRD : S_TW;
            end
          end
          ACT_LOAD_PAGE: begin
            if (rd_ent <= 0 || bad_pg_load) begin
              res_st_d = ST_ERR;
              state_d  = S_DONE;
            end else begin
              tw_addr_d[0] = ent_pg_sum[MEM_AW-1:0];
              tw_data_d[0] = val_q;
              mk_d[0]      = FRAME_BW'(val_frame);
              mk_n_d       = val_pos ? 2'd1 : 2'd0;
              state_d      = val_pos ? S_MRD : S_TW;
            end
          end
          default: begin
            if (rd_ent < 0) begin
              res_st_d = ST_FAULT;
              state_d  = S_DONE;
            end else if (rd_ent == 0) begin
              if (act_q == ACT_READ) begin
                res_st_d = ST_ERR;
                state_d  = S_DONE;
              end else begin
                // no page table yet: look for two adjacent free frames
                row_d       = '0;
                prev_free_d = 1'b0;
                scan_pair_d = 1'b1;
                have_pt_d   = 1'b0;
                state_d     = S_SRD;
              end
            end else begin
              t_raddr = ent_pg_sum[MEM_AW-1:0];
              state_d = S_RPG;
            end
          end
        endcase
      end
      S_RPG: begin
        if (rd_ent < 0) begin
          res_st_d = ST_FAULT;
          state_d  = S_DONE;
        end else if (rd_ent == 0) begin
          if (act_q == ACT_READ) begin
            res_st_d = ST_ERR;
            state_d  = S_DONE;
          end else begin
            // table present, page missing: look for one free frame
            row_d       = '0;
            prev_free_d = 1'b0;
            scan_pair_d = 1'b0;
            have_pt_d   = 1'b0;
            state_d     = S_SRD;
          end
        end else begin
          res_pa_d = ent_off_sum[ADDR_W-1:0];
          state_d  = S_DONE;
        end
      end
      S_SRD: begin
        bm_raddr = row_q;
        state_d  = S_SCHK;
      end
      S_SCHK: begin
        if (scan_pair_q && (pair_v != '0)) begin
          // table frames taken; restart first fit for the page frame
          pt_d        = pair_start;
          have_pt_d   = 1'b1;
          scan_pair_d = 1'b0;
          row_d       = '0;
          prev_free_d = 1'b0;
          state_d     = S_SRD;
        end else if (!scan_pair_q && (srch_free != '0)) begin
          res_pa_d = pga_off_sum[ADDR_W-1:0];
          if (have_pt_q) begin
            mk_d[0]      = pt_q;
            mk_d[1]      = pt_q + 1'b1;
            mk_d[2]      = single_frame;
            mk_n_d       = 2'd3;
            tw_addr_d[0] = MEM_AW'(seg_q);
            tw_data_d[0] = pta;
            tw_addr_d[1] = pta_pg_sum[MEM_AW-1:0];
            tw_data_d[1] = pga;
            tw_two_d     = 1'b1;
          end else begin
            mk_d[0]      = single_frame;
            mk_n_d       = 2'd1;
            tw_addr_d[0] = pg_addr_q;
            tw_data_d[0] = pga;
          end
          state_d = S_MRD;
        end else if (row_q == ROW_AW'(ROWS - 1)) begin
          // nothing free: report and leave all state as it was
          res_st_d = ST_OOF;
          state_d  = S_DONE;
        end else begin
          prev_free_d = srch_free[ROW_W-1];
          row_d       = row_q + 1'b1;
          state_d     = S_SRD;
        end
      end
      S_MRD: begin
        bm_raddr = mk_cur[FRAME_BW-1:ROW_BW];
        state_d  = S_MWR;
      end
      S_MWR: begin
        // set the frame bit; the next read follows this write, so no forwarding
        bm_we              = 1'b1;
        bm_waddr           = bm_rrow_q;
        bm_vld_d[bm_rrow_q] = 1'b1;
        mk_i_d             = mk_i_q + 1'b1;
        state_d            = (mk_i_q + 1'b1 == mk_n_q) ? S_TW : S_MRD;
      end
      S_TW: begin
        t_we    = 1'b1;
        t_waddr = tw_addr_q[tw_i_q];
        t_wdata = tw_data_q[tw_i_q];
        tw_i_d  = 1'b1;
        if (!tw_two_q || tw_i_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_st_d    = res_st_q;
          out_pa_d    = (res_st_q == ST_OK) ? res_pa_q : '0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      bm_vld_q    <= '0;
      row_q       <= '0;
      scan_pair_q <= 1'b0;
      have_pt_q   <= 1'b0;
      prev_free_q <= 1'b0;
      mk_n_q      <= '0;
      mk_i_q      <= '0;
      tw_two_q    <= 1'b0;
      tw_i_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      bm_vld_q    <= bm_vld_d;
      row_q       <= row_d;
      scan_pair_q <= scan_pair_d;
      have_pt_q   <= have_pt_d;
      prev_free_q <= prev_free_d;
      mk_n_q      <= mk_n_d;
      mk_i_q      <= mk_i_d;
      tw_two_q    <= tw_two_d;
      tw_i_q      <= tw_i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q     <= act_d;
    seg_q     <= seg_d;
    pg_q      <= pg_d;
    off_q     <= off_d;
    val_q     <= val_d;
    pg_addr_q <= pg_addr_d;
    pt_q      <= pt_d;
    mk_q      <= mk_d;
    tw_addr_q <= tw_addr_d;
    tw_data_q <= tw_data_d;
    res_st_q  <= res_st_d;
    res_pa_q  <= res_pa_d;
    out_st_q  <= out_st_d;
    out_pa_q  <= out_pa_d;
    bm_rrow_q <= bm_raddr;
  end

endmodule

/* rtl/spt_checker.sv */
// port-level checker for the translate block and its bind
`timescale 1ns / 1ps
`include "segment_page_translate_alloc_core_assert.svh"
module spt_checker import spt_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [STAT_W-1:0] status_i,
  input logic [ADDR_W-1:0] phys_addr_i
);
  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  `SPT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")
  `SPT_ASSERT_NOW(a_pa_zero, clk_i, rst_ni, out_valid_i && (status_i != ST_OK), phys_addr_i == '0, "address on failed item")
  `SPT_ASSERT_NEXT(a_one_item, clk_i, rst_ni, in_acc, !in_ready_i, "second item taken while busy")
  `SPT_ASSERT_NEXT(a_no_early_result, clk_i, rst_ni, in_acc, !$rose(out_valid_i), "result too early")
endmodule

bind segment_page_translate_alloc_core spt_checker u_spt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .status_i    (out_o.status),
  .phys_addr_i (out_o.phys_addr)
);

/* bench/segment_page_translate_alloc_checker.sv */
// result checker: mirrors the translation tables and compares every result item
`timescale 1ns / 1ps
module segment_page_translate_alloc_checker import spt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  spt_in_if    req_i,
  spt_out_if   res_i,
  output int   fail_count_o,
  output int   pending_o
);

  typedef struct packed {
    status_e           status;
    logic [ADDR_W-1:0] phys_addr;
  } xlat_result_t;

  logic [ENTRY_W-1:0] table_words [int];
  logic [USABLE-1:0]  frame_busy;
  xlat_result_t       result_fifo [$];

  assign pending_o = result_fifo.size();

  function automatic logic signed [ENTRY_W-1:0] word_at(input longint addr);
    int idx;
    idx = int'(addr & (MEM_WORDS - 1));
    return table_words.exists(idx) ? table_words[idx] : '0;
  endfunction

  function automatic int first_free_run(input int len);
    int run;
    int start;
    run = 0;
    start = 0;
    for (int i = 0; i < USABLE; i++) begin
      if (!frame_busy[i]) begin
        if (run == 0) start = i;
        run++;
        if (run == len) return start;
      end else begin
        run = 0;
      end
    end
    return -1;
  endfunction

  function automatic bit entry_fits(input logic signed [ENTRY_W-1:0] v, input int n);
    if (v == 0 || v == -1) return 1;
    if (v < 0) return 0;
    return (int'(v) / FRAME_WORDS) + n <= USABLE;
  endfunction

  task automatic put_word(input longint addr, input longint v);
    table_words[int'(addr & (MEM_WORDS - 1))] = ENTRY_W'(v);
  endtask

  task automatic translate_item(input action_e act, input int seg, input int pg,
                                input int off, input logic signed [ENTRY_W-1:0] v,
                                output xlat_result_t r);
    longint se;
    longint pe;
    int pt;
    int pf;
    r.status = ST_OK;
    r.phys_addr = '0;
    se = word_at(seg);
    case (act)
      ACT_LOAD_SEG: begin
        if (entry_fits(v, 2)) begin
          if (v > 0) begin
            frame_busy[int'(v) / FRAME_WORDS] = 1'b1;
            frame_busy[int'(v) / FRAME_WORDS + 1] = 1'b1;
          end
          put_word(seg, v);
        end else r.status = ST_ERR;
      end
      ACT_LOAD_PAGE: begin
        if (se <= 0 || !entry_fits(v, 1)) r.status = ST_ERR;
        else begin
          if (v > 0) frame_busy[int'(v) / FRAME_WORDS] = 1'b1;
          put_word(se + pg, v);
        end
      end
      default: begin
        if (se < 0) r.status = ST_FAULT;
        else if (se == 0) begin
          if (act == ACT_READ) r.status = ST_ERR;
          else begin
            // new segment needs a two-frame table and then one page frame
            pt = first_free_run(2);
            if (pt < 0) r.status = ST_OOF;
            else begin
              frame_busy[pt] = 1'b1;
              frame_busy[pt + 1] = 1'b1;
              pf = first_free_run(1);
              if (pf < 0) begin
                frame_busy[pt] = 1'b0;
                frame_busy[pt + 1] = 1'b0;
                r.status = ST_OOF;
              end else begin
                frame_busy[pf] = 1'b1;
                put_word(seg, longint'(pt) * FRAME_WORDS);
                put_word(longint'(pt) * FRAME_WORDS + pg, longint'(pf) * FRAME_WORDS);
                r.phys_addr = ADDR_W'(longint'(pf) * FRAME_WORDS + off);
              end
            end
          end
        end else begin
          pe = word_at(se + pg);
          if (pe < 0) r.status = ST_FAULT;
          else if (pe == 0) begin
            if (act == ACT_READ) r.status = ST_ERR;
            else begin
              pf = first_free_run(1);
              if (pf < 0) r.status = ST_OOF;
              else begin
                frame_busy[pf] = 1'b1;
                put_word(se + pg, longint'(pf) * FRAME_WORDS);
                r.phys_addr = ADDR_W'(longint'(pf) * FRAME_WORDS + off);
              end
            end
          end else r.phys_addr = ADDR_W'(pe + off);
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    xlat_result_t want;
    xlat_result_t got;
    if (!rst_ni) begin
      table_words.delete();
      frame_busy = '0;
      frame_busy[0] = 1'b1;
      result_fifo.delete();
      fail_count_o <= 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        got.status = status_e'(res_i.status);
        got.phys_addr = res_i.phys_addr;
        if (result_fifo.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result item: status %0d addr 0x%05h",
                                          got.status, got.phys_addr);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = result_fifo.pop_front();
          if (want != got) begin
            if (fail_count_o < 10)
              $display("mismatch: expected status %0d addr 0x%05h, got status %0d addr 0x%05h",
                       want.status, want.phys_addr, got.status, got.phys_addr);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        translate_item(action_e'(req_i.action), int'(req_i.segment), int'(req_i.page),
                       int'(req_i.offset), req_i.entry_value, want);
        result_fifo.push_back(want);
      end
    end
  end

endmodule

/* bench/segment_page_translate_alloc_core_test.sv */
// testbench top: stimulus, handshake pacing and final verdict for the translate core
`timescale 1ns / 1ps
module segment_page_translate_alloc_core_test;
  import spt_pkg::*;

  localparam int WATCHDOG_LIMIT = 700000; // covers the post-reset clearing pass
  localparam int RX_HOLD_CYCLES = 400;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   idle_cycles;
  bit   rx_hold_req;
  bit   calm;

  spt_in_if  req_if ();
  spt_out_if res_if ();

  segment_page_translate_alloc_core i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (res_if)
  );

  segment_page_translate_alloc_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .res_i       (res_if),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // mostly short gaps, now and then a long one; none while calm
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (calm || p < 60) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // result side: random back-pressure plus one long hold on request
  always @(posedge clk_i or negedge rst_ni) begin
    int stall_left;
    bit hold_taken;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      stall_left = 0;
      hold_taken = 0;
    end else if (rx_hold_req && !hold_taken) begin
      hold_taken = 1;
      stall_left = RX_HOLD_CYCLES;
      res_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      res_if.ready <= (stall_left == 0);
    end else if (res_if.ready && res_if.valid) begin
      stall_left = gap_len();
      res_if.ready <= (stall_left == 0);
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // watchdog on cycles with no item moving on either channel
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) idle_cycles <= 0;
    else if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
      idle_cycles <= 0;
    else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  task automatic send_item(input action_e act, input int seg, input int pg, input int off,
                           input int v);
    int gap;
    req_if.valid       <= 1'b1;
    req_if.action      <= act;
    req_if.segment     <= SEG_W'(seg);
    req_if.page        <= PAGE_W'(pg);
    req_if.offset      <= OFF_W'(off);
    req_if.entry_value <= ENTRY_W'(v);
    do @(posedge clk_i); while (!req_if.ready);
    gap = gap_len();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // load value mix: mostly frame addresses, some absent/unallocated/raw bits
  function automatic logic signed [ENTRY_W-1:0] load_value();
    int p;
    p = $urandom_range(99);
    if (p < 60) return ENTRY_W'($urandom_range(USABLE - 1, 1) * FRAME_WORDS
                               + $urandom_range(FRAME_WORDS - 1));
    if (p < 75) return ENTRY_W'(-1);
    if (p < 85) return '0;
    return ENTRY_W'($urandom);
  endfunction

  task automatic random_item();
    int p;
    int seg;
    action_e act;
    p = $urandom_range(99);
    act = (p < 35) ? ACT_WRITE : (p < 70) ? ACT_READ : (p < 85) ? ACT_LOAD_PAGE : ACT_LOAD_SEG;
    // a small segment pool keeps tables being reused
    seg = ($urandom_range(99) < 80) ? $urandom_range(15) : $urandom_range(511);
    send_item(act, seg, ($urandom_range(99) < 70) ? $urandom_range(31) : $urandom_range(1023),
              $urandom_range(511), (act inside {ACT_LOAD_SEG, ACT_LOAD_PAGE}) ? load_value()
                                                                          : ENTRY_W'($urandom));
  endtask

  initial begin
    req_if.valid       <= 1'b0;
    req_if.action      <= ACT_READ;
    req_if.segment     <= '0;
    req_if.page        <= '0;
    req_if.offset      <= '0;
    req_if.entry_value <= '0;
    rx_hold_req = 0;
    calm = 0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: error, allocation, hits, faults, bad loads, field extremes
    send_item(ACT_READ,      3,   5,    7,   0);            // read of unallocated segment
    send_item(ACT_WRITE,     3,   5,    7,   0);            // allocates table and page
    send_item(ACT_READ,      3,   5,    511, -1);           // hit
    send_item(ACT_WRITE,     3,   1023, 0,   0);            // allocates page only
    send_item(ACT_READ,      3,   6,    0,   0);            // unallocated page read
    send_item(ACT_LOAD_PAGE, 3,   6,    0,   -1);           // absent page
    send_item(ACT_READ,      3,   6,    1,   0);            // page fault
    send_item(ACT_WRITE,     3,   6,    1,   0);            // write fault
    send_item(ACT_LOAD_PAGE, 3,   7,    0,   524287);       // top frame, top word
    send_item(ACT_READ,      3,   7,    511, 0);            // address wraps to 19 bits
    send_item(ACT_LOAD_SEG,  9,   0,    0,   -1);           // absent segment
    send_item(ACT_READ,      9,   0,    0,   0);
    send_item(ACT_WRITE,     9,   0,    0,   0);
    send_item(ACT_LOAD_PAGE, 9,   0,    0,   4096);         // page load on absent segment
    send_item(ACT_LOAD_PAGE, 20,  0,    0,   4096);         // page load on unallocated segment
    send_item(ACT_LOAD_SEG,  10,  0,    0,   -2);           // below absent
    send_item(ACT_LOAD_SEG,  10,  0,    0,   -524288);      // most negative
    send_item(ACT_LOAD_SEG,  10,  0,    0,   1023 * 512);   // table past last frame
    send_item(ACT_LOAD_SEG,  511, 0,    0,   1022 * 512);   // last usable table
    send_item(ACT_LOAD_PAGE, 511, 1023, 511, 300 * 512 + 17);// page index reaches the last memory word
    send_item(ACT_READ,      511, 1023, 511, 0);
    send_item(ACT_LOAD_SEG,  511, 0,    0,   0);            // back to unallocated
    send_item(ACT_WRITE,     511, 512,  256, 0);
    send_item(ACT_LOAD_PAGE, 0,   3,    0,   0);            // segment table's own entry

    // random traffic, with a long receiver hold and a full drain along the way
    for (int i = 0; i < 300; i++) begin
      if (i == 60) rx_hold_req = 1;
      if (i == 130) wait_drained();
      calm = (i >= 200 && i < 250);
      random_item();
    end
    calm = 0;

    // fill the bitmap through table loads, leaving the last frame pair free
    for (int f = 0; f < USABLE - 2; f += 2) begin
      send_item(ACT_LOAD_SEG, 500, 0, 0, f * FRAME_WORDS + int'($urandom_range(511)));
      if ($urandom_range(9) == 0) random_item();
    end
    send_item(ACT_LOAD_SEG,  499, 0,  0, 0);
    send_item(ACT_WRITE,     499, 4,  9, 0);                // table fits, page does not
    send_item(ACT_LOAD_SEG,  498, 0,  0, 2 * FRAME_WORDS);
    send_item(ACT_WRITE,     498, 40, 9, 0);                // takes one of the last frames
    send_item(ACT_WRITE,     498, 41, 9, 0);                // takes the final frame
    for (int i = 0; i < 60; i++) random_item();             // mostly out of frames now

    wait_drained();
    repeat (300) @(posedge clk_i);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
